// ===== design/latency_histogram_binner_assert.svh =====
// Assertion macros shared by the histogram binner RTL.
// No dependencies; included by design files that check their own logic.
`ifndef LATENCY_HISTOGRAM_BINNER_ASSERT_SVH
`define LATENCY_HISTOGRAM_BINNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LHB_ASSERT_NOW(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LHB_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lhb_pkg.sv =====
// Types, codes and constants of the latency histogram binner.
// No dependencies; used by the top level by scoped names.
`default_nettype none

package lhb_pkg;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_PICK,
		S_FETCH,
		S_DONE
	} state_t;

	localparam int TS_W       = 63;
	localparam int SR_W       = 64;
	localparam int DIG_W      = 4;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 16;
	localparam int BINS_W     = 5;
	localparam int DIV_W      = 36;
	localparam int NSM_W      = 20;
	localparam int DCNT_W     = 4;

	localparam logic [DCNT_W-1:0] DIG_LAST      = 4'd15;
	localparam logic [NSM_W-1:0]  NS_PER_MS     = 20'd1000000;
	localparam logic [CNT_W-1:0]  CNT_MAX       = 32'hFFFF_FFFF;
	localparam logic [CFG_W-1:0]  BIN_SIZE_RST  = 16'd10;
	localparam logic [BINS_W-1:0] BINS_RST      = 5'd16;

	localparam logic REG_BIN_SIZE    = 1'b0;
	localparam logic REG_BINS_IN_USE = 1'b1;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

`default_nettype wire

// ===== design/lhb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the bin counters of the histogram binner.
`default_nettype none

module lhb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                     wdata,
	input  wire                                  re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/latency_histogram_binner.sv =====
// Latency histogram binner: nibble-serial duration binning and bin counters.
// Depends on lhb_pkg, lhb_ram and latency_histogram_binner_assert.svh.
//
// Usage:
//   Issue a command by raising start with operation and its operands; it is
//   taken at a clock edge where start is high and busy is low. Operation add
//   bins end_ns - start_ns by bin_size_ms milliseconds, clear zeroes all
//   counters, read returns the count of bin read_index.
//   Each command gives one result: done is high for one cycle with
//   bin_selected, bin_value and sample_total valid in that cycle. The
//   receiver cannot hold a result off; it must take it on that cycle.
//   An add passes through the run, pick, fetch and done states; every other
//   command goes straight to fetch and done. The run state subtracts the
//   duration and compares it against all bin bounds one 4-bit digit a
//   cycle, 16 digits for the 63-bit timestamps. busy drops in the cycle
//   done is high, so a new command may be issued then; no new command is
//   taken while an earlier one is in progress. Configuration (cfg_write,
//   cfg_index, cfg_data) is to be written while idle; the block itself
//   does not enforce this. Reset clears all counters and loads bin width
//   10 ms and 16 bins; the block is ready in the first cycle after reset.
`default_nettype none

module latency_histogram_binner #(
	parameter int NUM_BINS = 16
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire  [1:0]                      operation,
	input  wire  [lhb_pkg::TS_W-1:0]        start_ns,
	input  wire  [lhb_pkg::TS_W-1:0]        end_ns,
	input  wire  [3:0]                      read_index,
	input  wire                             cfg_write,
	input  wire                             cfg_index,
	input  wire  [lhb_pkg::CFG_W-1:0]       cfg_data,
	output logic                            done,
	output logic [3:0]                      bin_selected,
	output logic [lhb_pkg::CNT_W-1:0]       bin_value,
	output logic [lhb_pkg::CNT_W-1:0]       sample_total
);

`include "latency_histogram_binner_assert.svh"

	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int LANES = (NUM_BINS > 1) ? NUM_BINS - 1 : 1;
	localparam int KW    = $clog2(LANES + 1);
	localparam int PW    = lhb_pkg::DIG_W + KW;

	lhb_pkg::state_t state_q, state_d;

	logic [lhb_pkg::CFG_W-1:0]  bin_size_q;
	logic [lhb_pkg::BINS_W-1:0] bins_q;

	lhb_pkg::op_t               op_q;
	logic [3:0]                 read_index_q;
	logic                       rd_ok_q;
	logic [BIN_W-1:0]           sel_q;

	logic [lhb_pkg::SR_W-1:0]   end_sr_q;
	logic [lhb_pkg::SR_W-1:0]   start_sr_q;
	logic [lhb_pkg::DIV_W-1:0]  div_sr_q;
	logic [lhb_pkg::DCNT_W-1:0] dig_q;
	logic                       borrow_q;
	logic [KW-1:0]              lane_carry_q [LANES];
	logic [LANES-1:0]           lane_ge_q;

	logic [NUM_BINS-1:0]        valid_q;
	logic [lhb_pkg::CNT_W-1:0]  total_q;

	logic                       done_q;
	logic [3:0]                 bin_selected_q;
	logic [lhb_pkg::CNT_W-1:0]  bin_value_q;
	logic [lhb_pkg::CNT_W-1:0]  sample_total_q;

	logic                       accept;
	logic                       ram_we;
	logic                       ram_re;
	logic [lhb_pkg::CNT_W-1:0]  ram_rdata;
	logic [lhb_pkg::CNT_W-1:0]  cur_cnt;
	logic [lhb_pkg::CNT_W-1:0]  new_cnt;
	logic [lhb_pkg::CNT_W-1:0]  new_total;
	logic [lhb_pkg::CFG_W-1:0]  width_eff;
	logic [BIN_W-1:0]           last_bin;
	logic [4:0]                 diff;
	logic [PW-1:0]              lane_prod [LANES];
	logic [LANES-1:0]           lane_ge_d;
	logic [BIN_W-1:0]           pick_idx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_size_q <= lhb_pkg::BIN_SIZE_RST;
			bins_q     <= lhb_pkg::BINS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				lhb_pkg::REG_BIN_SIZE:    bin_size_q <= cfg_data;
				lhb_pkg::REG_BINS_IN_USE: bins_q     <= cfg_data[lhb_pkg::BINS_W-1:0];
				default:                  bin_size_q <= bin_size_q;
			endcase
		end
	end

	always_comb begin
		width_eff = (bin_size_q == '0) ? lhb_pkg::CFG_W'(1) : bin_size_q;
		if (bins_q == '0) begin
			last_bin = '0;
		end else if (9'(bins_q) >= 9'(NUM_BINS)) begin
			last_bin = BIN_W'(NUM_BINS - 1);
		end else begin
			last_bin = BIN_W'(bins_q - 5'd1);
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != lhb_pkg::S_IDLE);
		accept  = start && !busy;
		ram_re  = (state_q == lhb_pkg::S_FETCH);
		ram_we  = (state_q == lhb_pkg::S_DONE) && (op_q == lhb_pkg::OP_ADD);
		case (state_q)
			lhb_pkg::S_IDLE: begin
				if (start) begin
					state_d = (lhb_pkg::op_t'(operation) == lhb_pkg::OP_ADD) ?
						lhb_pkg::S_RUN : lhb_pkg::S_FETCH;
				end
			end
			lhb_pkg::S_RUN: begin
				if (dig_q == lhb_pkg::DIG_LAST) begin
					state_d = lhb_pkg::S_PICK;
				end
			end
			lhb_pkg::S_PICK:  state_d = lhb_pkg::S_FETCH;
			lhb_pkg::S_FETCH: state_d = lhb_pkg::S_DONE;
			lhb_pkg::S_DONE:  state_d = lhb_pkg::S_IDLE;
			default:          state_d = lhb_pkg::S_IDLE;
		endcase
	end

	// Digit-serial subtract and compare against every bin bound k * width * 1e6
	always_comb begin
		diff = {1'b0, end_sr_q[lhb_pkg::DIG_W-1:0]} - {1'b0, start_sr_q[lhb_pkg::DIG_W-1:0]}
			- {4'b0, borrow_q};
		for (int i = 0; i < LANES; i++) begin
			lane_prod[i] = PW'(div_sr_q[lhb_pkg::DIG_W-1:0]) * PW'(i + 1)
				+ PW'(lane_carry_q[i]);
			if (diff[3:0] > lane_prod[i][lhb_pkg::DIG_W-1:0]) begin
				lane_ge_d[i] = 1'b1;
			end else if (diff[3:0] < lane_prod[i][lhb_pkg::DIG_W-1:0]) begin
				lane_ge_d[i] = 1'b0;
			end else begin
				lane_ge_d[i] = lane_ge_q[i];
			end
		end
	end

	// Highest bound passed, clamped to the last bin in use; bin 0 if the duration is negative
	always_comb begin
		logic [LANES-1:0] ge_m;
		logic             nxt;
		pick_idx = '0;
		nxt      = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			ge_m[i] = lane_ge_q[i] && ((BIN_W + 1)'(i + 1) <= {1'b0, last_bin});
		end
		for (int i = 0; i < LANES; i++) begin
			nxt = (i + 1 < LANES) ? ge_m[(i + 1) % LANES] : 1'b0;
			if (ge_m[i] && !nxt) begin
				pick_idx = pick_idx | BIN_W'(i + 1);
			end
		end
		if (borrow_q) begin
			pick_idx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= lhb_pkg::op_t'(operation);
			read_index_q <= read_index;
			rd_ok_q      <= (9'(read_index) < 9'(NUM_BINS));
			sel_q        <= (lhb_pkg::op_t'(operation) == lhb_pkg::OP_READ) ?
				BIN_W'(read_index) : '0;
			end_sr_q     <= {1'b0, end_ns};
			start_sr_q   <= {1'b0, start_ns};
			div_sr_q     <= lhb_pkg::DIV_W'(width_eff) * lhb_pkg::DIV_W'(lhb_pkg::NS_PER_MS);
			dig_q        <= '0;
			borrow_q     <= 1'b0;
			lane_ge_q    <= '1;
			for (int i = 0; i < LANES; i++) begin
				lane_carry_q[i] <= '0;
			end
		end else if (state_q == lhb_pkg::S_RUN) begin
			end_sr_q   <= end_sr_q >> lhb_pkg::DIG_W;
			start_sr_q <= start_sr_q >> lhb_pkg::DIG_W;
			div_sr_q   <= div_sr_q >> lhb_pkg::DIG_W;
			dig_q      <= dig_q + 4'd1;
			borrow_q   <= diff[4];
			lane_ge_q  <= lane_ge_d;
			for (int i = 0; i < LANES; i++) begin
				lane_carry_q[i] <= lane_prod[i][PW-1:lhb_pkg::DIG_W];
			end
		end else if (state_q == lhb_pkg::S_PICK) begin
			sel_q <= pick_idx;
		end
	end

	// Bin counters
	lhb_ram #(
		.WIDTH(lhb_pkg::CNT_W),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(sel_q),
		.wdata(new_cnt),
		.re   (ram_re),
		.raddr(sel_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		cur_cnt   = valid_q[sel_q] ? ram_rdata : '0;
		new_cnt   = lhb_pkg::sat_inc(cur_cnt);
		new_total = lhb_pkg::sat_inc(total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == lhb_pkg::S_DONE);
			if (state_q == lhb_pkg::S_DONE) begin
				case (op_q)
					lhb_pkg::OP_ADD: begin
						valid_q[sel_q] <= 1'b1;
						total_q        <= new_total;
					end
					lhb_pkg::OP_CLEAR: begin
						valid_q <= '0;
						total_q <= '0;
					end
					default: total_q <= total_q;
				endcase
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == lhb_pkg::S_DONE) begin
			case (op_q)
				lhb_pkg::OP_ADD: begin
					bin_selected_q <= 4'(sel_q);
					bin_value_q    <= new_cnt;
					sample_total_q <= new_total;
				end
				lhb_pkg::OP_CLEAR: begin
					bin_selected_q <= '0;
					bin_value_q    <= '0;
					sample_total_q <= '0;
				end
				lhb_pkg::OP_READ: begin
					bin_selected_q <= read_index_q;
					bin_value_q    <= rd_ok_q ? cur_cnt : '0;
					sample_total_q <= total_q;
				end
				default: begin
					bin_selected_q <= '0;
					bin_value_q    <= cur_cnt;
					sample_total_q <= total_q;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign bin_selected = bin_selected_q;
	assign bin_value    = bin_value_q;
	assign sample_total = sample_total_q;

	`LHB_ASSERT_NEXT(a_done_after_update, clk, arst_n, state_q == lhb_pkg::S_DONE, done, "done must follow the update cycle")
	`LHB_ASSERT_NOW(a_done_ready, clk, arst_n, done, !busy, "busy high while a result is shown")
	`LHB_ASSERT_NEXT(a_clear_zero, clk, arst_n, (state_q == lhb_pkg::S_DONE) && (op_q == lhb_pkg::OP_CLEAR), (sample_total == '0) && (bin_value == '0), "clear result not zero")
	`LHB_ASSERT_NEXT(a_add_counts, clk, arst_n, (state_q == lhb_pkg::S_DONE) && (op_q == lhb_pkg::OP_ADD), (sample_total != '0) && (bin_value != '0), "add left a zero count")

endmodule

`default_nettype wire

// ===== test/latency_histogram_binner_tb.sv =====
// Testbench for latency_histogram_binner: drives add, clear, read and unused commands and
// checks each result against a histogram tracker kept in the bench.
// Depends on lhb_pkg and the latency_histogram_binner RTL.
`timescale 1ns / 100ps

module latency_histogram_binner_tb;

	localparam int          NBINS        = 16;
	localparam logic [63:0] MS_NS        = 64'd1_000_000;
	localparam logic [63:0] MS_CEIL      = 64'h7FFF_FFFF;
	localparam logic [62:0] TS_TOP       = '1;
	localparam int          DRAIN_CYCLES = 25;
	localparam int          CYCLE_LIMIT  = 400_000;
	localparam int          PHASE_ITEMS  = 155;

	typedef struct packed {
		logic [3:0]  sel;
		logic [31:0] count;
		logic [31:0] total;
	} bin_result_t;

	class bin_count_tracker;
		bit [31:0]   counts [NBINS];
		bit [31:0]   total;
		bit [15:0]   width_ms;
		bit [4:0]    bins_used;
		int          errors;
		bin_result_t pending [$];

		function new();
			foreach (counts[i]) counts[i] = 32'd0;
			total     = 32'd0;
			width_ms  = 16'd10;
			bins_used = 5'd16;
			errors    = 0;
		endfunction

		function void write_reg(logic idx, logic [15:0] data);
			if (idx == lhb_pkg::REG_BIN_SIZE)
				width_ms = data;
			else
				bins_used = data[4:0];
		endfunction

		function int unsigned live_bins();
			if (bins_used == 5'd0)
				return 1;
			if (bins_used > NBINS)
				return NBINS;
			return bins_used;
		endfunction

		function int unsigned live_width();
			return (width_ms == 16'd0) ? 1 : width_ms;
		endfunction

		function bit [31:0] bump(bit [31:0] v);
			return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
		endfunction

		function bit [3:0] pick_bin(bit [62:0] from_ns, bit [62:0] to_ns);
			bit [63:0] ms;
			bit [63:0] idx;
			bit [63:0] last;
			last = 64'(live_bins() - 1);
			if (to_ns < from_ns)
				return 4'd0;
			ms = ({1'b0, to_ns} - {1'b0, from_ns}) / MS_NS;
			if (ms > MS_CEIL)
				return last[3:0];
			idx = ms / live_width();
			return (idx > last) ? last[3:0] : idx[3:0];
		endfunction

		function void note_command(lhb_pkg::op_t op, bit [62:0] from_ns, bit [62:0] to_ns,
				bit [3:0] idx);
			bin_result_t r;
			r.sel   = 4'd0;
			r.count = 32'd0;
			case (op)
			lhb_pkg::OP_ADD: begin
				r.sel         = pick_bin(from_ns, to_ns);
				counts[r.sel] = bump(counts[r.sel]);
				total         = bump(total);
				r.count       = counts[r.sel];
			end
			lhb_pkg::OP_CLEAR: begin
				foreach (counts[i]) counts[i] = 32'd0;
				total = 32'd0;
			end
			lhb_pkg::OP_READ: begin
				r.sel   = idx;
				r.count = counts[idx];
			end
			default: begin
				r.count = counts[0];
			end
			endcase
			r.total = total;
			pending.push_back(r);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task check_result(logic [3:0] sel, logic [31:0] count, logic [31:0] tot);
			bin_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result sel=%0d count=%0d total=%0d with no command open",
					sel, count, tot));
			end else begin
				want = pending.pop_front();
				if (sel !== want.sel)
					report($sformatf("bin_selected got %0d want %0d", sel, want.sel));
				if (count !== want.count)
					report($sformatf("bin_value got %0d want %0d", count, want.count));
				if (tot !== want.total)
					report($sformatf("sample_total got %0d want %0d", tot, want.total));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [1:0]  operation;
	logic [62:0] start_ns;
	logic [62:0] end_ns;
	logic [3:0]  read_index;
	logic        cfg_write;
	logic        cfg_index;
	logic [15:0] cfg_data;
	wire         busy;
	wire         done;
	wire  [3:0]  bin_selected;
	wire  [31:0] bin_value;
	wire  [31:0] sample_total;

	bin_count_tracker tracker;
	int               idle_pct;
	int               cycles = 0;

	latency_histogram_binner u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.start_ns     (start_ns),
		.end_ns       (end_ns),
		.read_index   (read_index),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.bin_selected (bin_selected),
		.bin_value    (bin_value),
		.sample_total (sample_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[latency_histogram_binner] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(bin_selected, bin_value, sample_total);
	end

	function automatic logic [62:0] rand_ts();
		return {31'($urandom), 32'($urandom)};
	endfunction

	task automatic issue(lhb_pkg::op_t op, logic [62:0] from_ns, logic [62:0] to_ns,
			logic [3:0] idx);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		start_ns   <= from_ns;
		end_ns     <= to_ns;
		read_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.note_command(op, from_ns, to_ns, idx);
		@(negedge clk);
	endtask

	task automatic add_span(logic [63:0] from_ns, logic [63:0] dur);
		logic [63:0] to_ns;
		to_ns = from_ns + dur;
		issue(lhb_pkg::OP_ADD, from_ns[62:0], to_ns[62:0], 4'($urandom));
	endtask

	task automatic settle();
		start <= 1'b0;
		while (tracker.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_add();
		logic [63:0]  from_ns;
		logic [63:0]  to_ns;
		logic [63:0]  dur;
		int unsigned  w;
		int unsigned  n;
		int unsigned  k;
		bit           paired;
		w       = tracker.live_width();
		n       = tracker.live_bins();
		from_ns = {1'b0, rand_ts()};
		to_ns   = {1'b0, rand_ts()};
		dur     = 64'd0;
		paired  = 1'b0;
		case ($urandom_range(9))
		0, 1, 2, 3, 4, 5: dur = 64'($urandom_range(n * w + 2 * w)) * MS_NS
			+ $urandom_range(999_999);
		6: begin
			k   = $urandom_range(n);
			dur = 64'(k * w) * MS_NS;
			if (dur != 64'd0 && $urandom_range(1) == 1)
				dur = dur - 64'd1;
		end
		7: dur = (MS_CEIL + $urandom_range(2)) * MS_NS + $urandom_range(999_999);
		8: dur = {1'b0, rand_ts()};
		default: begin
			paired = 1'b1;
			if ($urandom_range(1) == 1 && from_ns > 64'd50_000_001)
				to_ns = from_ns - 64'd1 - $urandom_range(50_000_000);
		end
		endcase
		if (!paired) begin
			from_ns = from_ns % ({1'b0, TS_TOP} - dur + 64'd1);
			to_ns   = from_ns + dur;
		end
		issue(lhb_pkg::OP_ADD, from_ns[62:0], to_ns[62:0], 4'($urandom));
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 68)
			random_add();
		else if (pick < 88)
			issue(lhb_pkg::OP_READ, rand_ts(), rand_ts(), 4'($urandom));
		else if (pick < 94)
			issue(lhb_pkg::OP_NONE, rand_ts(), rand_ts(), 4'($urandom));
		else
			issue(lhb_pkg::OP_CLEAR, rand_ts(), rand_ts(), 4'($urandom));
	endtask

	task automatic directed();
		logic [63:0] base;
		base = 64'h0000_1234_5678_9ABC;
		add_span(64'd0, 64'd0);
		issue(lhb_pkg::OP_ADD, 63'd1000, 63'd999, 4'd0);
		issue(lhb_pkg::OP_ADD, 63'd0, TS_TOP, 4'd15);
		issue(lhb_pkg::OP_ADD, TS_TOP, TS_TOP, 4'd0);
		issue(lhb_pkg::OP_ADD, TS_TOP, 63'd0, 4'd15);
		add_span(base, 10 * MS_NS - 64'd1);
		add_span(base, 10 * MS_NS);
		add_span(base, 155 * MS_NS + 64'd999_999);
		add_span(base, 170 * MS_NS);
		add_span(64'd0, MS_CEIL * MS_NS + 64'd999_999);
		add_span(base, (MS_CEIL + 64'd1) * MS_NS);
		add_span(base, 64'h1_0000_0003 * MS_NS);
		add_span(base, 25 * MS_NS);
		issue(lhb_pkg::OP_READ, rand_ts(), rand_ts(), 4'd0);
		issue(lhb_pkg::OP_READ, rand_ts(), rand_ts(), 4'd1);
		issue(lhb_pkg::OP_READ, rand_ts(), rand_ts(), 4'd2);
		issue(lhb_pkg::OP_READ, TS_TOP, TS_TOP, 4'd15);
		issue(lhb_pkg::OP_NONE, rand_ts(), rand_ts(), 4'd15);
		issue(lhb_pkg::OP_CLEAR, rand_ts(), rand_ts(), 4'd15);
		issue(lhb_pkg::OP_READ, rand_ts(), rand_ts(), 4'd15);
		issue(lhb_pkg::OP_NONE, 63'd0, 63'd0, 4'd0);
		add_span(base, 3 * MS_NS);
		issue(lhb_pkg::OP_READ, 63'd0, 63'd0, 4'd0);
	endtask

	initial begin
		tracker    = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		operation  = lhb_pkg::OP_ADD;
		start_ns   = '0;
		end_ns     = '0;
		read_index = '0;
		cfg_write  = 1'b0;
		cfg_index  = 1'b0;
		cfg_data   = '0;
		idle_pct   = 15;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed();

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
			0: begin
				write_reg(lhb_pkg::REG_BIN_SIZE, 16'd1);
				write_reg(lhb_pkg::REG_BINS_IN_USE, 16'd1);
			end
			1: begin
				write_reg(lhb_pkg::REG_BIN_SIZE, 16'hFFFF);
				write_reg(lhb_pkg::REG_BINS_IN_USE, 16'd16);
			end
			2: begin
				idle_pct = 82;
				write_reg(lhb_pkg::REG_BIN_SIZE, 16'd0);
				write_reg(lhb_pkg::REG_BINS_IN_USE, 16'd0);
			end
			3: begin
				write_reg(lhb_pkg::REG_BIN_SIZE, 16'd7);
				write_reg(lhb_pkg::REG_BINS_IN_USE, {11'($urandom), 5'd31});
			end
			4: begin
				idle_pct = 0;
				write_reg(lhb_pkg::REG_BIN_SIZE, 16'($urandom_range(40, 1)));
				write_reg(lhb_pkg::REG_BINS_IN_USE, 16'($urandom_range(31)));
			end
			default: begin
				write_reg(lhb_pkg::REG_BIN_SIZE, 16'd10);
				write_reg(lhb_pkg::REG_BINS_IN_USE, 16'd16);
			end
			endcase
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		if (tracker.errors == 0)
			$display("[latency_histogram_binner] OK");
		else
			$display("[latency_histogram_binner] ERROR");
		$finish;
	end

endmodule
